[rtl/ddpu_pkg.sv]
// ----------------------------------------------------------------------------
// ddpu_pkg
// Shared types, constants and tables of the differential drive pose update.
// ----------------------------------------------------------------------------
package ddpu_pkg;

   localparam int POSITION_WIDTH_DEFAULT = 32;
   localparam int ANGLE_WIDTH_DEFAULT    = 16;
   localparam int FRAC_BITS              = 12;
   localparam int TURN_BITS              = 28;
   localparam int CORDIC_STEPS           = 16;
   localparam int STEP_BITS              = 4;
   localparam int TRIG_WIDTH             = 32;
   localparam logic [31:0] CORDIC_X0     = 32'd652032874;
   localparam logic [16:0] STEP_GAIN     = 17'd66754;
   localparam int CSR_ADDR_WIDTH         = 4;

   localparam logic [1:0] REG_HALF_BASE     = 2'd0;
   localparam logic [1:0] REG_START_X       = 2'd1;
   localparam logic [1:0] REG_START_Y       = 2'd2;
   localparam logic [1:0] REG_START_HEADING = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROT_RIGHT,
      ST_APPLY_RIGHT,
      ST_ROT_LEFT,
      ST_APPLY_LEFT,
      ST_ROT_RELOAD,
      ST_APPLY_RELOAD,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      APPLY_NONE,
      APPLY_RIGHT,
      APPLY_LEFT,
      APPLY_RELOAD
   } apply_type;

   typedef struct packed {
      logic      load;
      logic      start_right;
      logic      start_left;
      logic      start_reload;
      logic      cordic_step;
      apply_type apply;
      logic      result_load;
   } cmd_type;

   typedef struct packed {
      logic reload;
      logic right_moves;
      logic left_moves;
      logic cordic_last;
   } status_type;

   function automatic logic [27:0] atan_unit(input logic [STEP_BITS-1:0] i);
      logic [27:0] v;
      unique case (i)
         4'd0:  v = 28'd33554432;
         4'd1:  v = 28'd19808338;
         4'd2:  v = 28'd10466078;
         4'd3:  v = 28'd5312799;
         4'd4:  v = 28'd2666708;
         4'd5:  v = 28'd1334654;
         4'd6:  v = 28'd667490;
         4'd7:  v = 28'd333765;
         4'd8:  v = 28'd166885;
         4'd9:  v = 28'd83443;
         4'd10: v = 28'd41722;
         4'd11: v = 28'd20861;
         4'd12: v = 28'd10430;
         4'd13: v = 28'd5215;
         4'd14: v = 28'd2608;
         default: v = 28'd1304;
      endcase
      return v;
   endfunction

endpackage

[rtl/ddpu_if.sv]
// ----------------------------------------------------------------------------
// ddpu_req_if / ddpu_rsp_if
// Valid/ready channels for speed items and pose results.
// ----------------------------------------------------------------------------
interface ddpu_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_speed;
   logic signed [15:0] right_speed;
   logic               reload;
   modport source (output valid, left_speed, right_speed, reload, input ready);
   modport sink   (input valid, left_speed, right_speed, reload, output ready);
endinterface

interface ddpu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] center_x;
   logic signed [31:0] center_y;
   logic        [15:0] heading;
   logic signed [31:0] left_wheel_x_out;
   logic signed [31:0] right_wheel_x_out;
   modport source (output valid, center_x, center_y, heading, left_wheel_x_out,
                   right_wheel_x_out, input ready);
   modport sink   (input valid, center_x, center_y, heading, left_wheel_x_out,
                   right_wheel_x_out, output ready);
endinterface

[rtl/ddpu_ctrl.sv]
// ----------------------------------------------------------------------------
// ddpu_ctrl
// Sequencer: reload or up to two swings, each one CORDIC pass, then the result.
// ----------------------------------------------------------------------------
module ddpu_ctrl
   import ddpu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.apply    = APPLY_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ROT_RIGHT;
            end
         end
         ST_ROT_RIGHT: begin
            if (status.reload) begin
               cmd.start_reload = 1'b1;
               state_in         = ST_ROT_RELOAD;
            end else if (status.right_moves) begin
               cmd.start_right = 1'b1;
               state_in        = ST_APPLY_RIGHT;
            end else if (status.left_moves) begin
               cmd.start_left = 1'b1;
               state_in       = ST_APPLY_LEFT;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_APPLY_RIGHT: begin
            cmd.cordic_step = 1'b1;
            if (status.cordic_last) state_in = ST_ROT_LEFT;
         end
         ST_ROT_LEFT: begin
            cmd.apply = APPLY_RIGHT;
            if (status.left_moves) begin
               cmd.start_left = 1'b1;
               state_in       = ST_APPLY_LEFT;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_APPLY_LEFT: begin
            cmd.cordic_step = 1'b1;
            if (status.cordic_last) state_in = ST_ROT_RELOAD;
         end
         ST_ROT_RELOAD: begin
            if (status.reload) begin
               cmd.cordic_step = 1'b1;
               if (status.cordic_last) state_in = ST_APPLY_RELOAD;
            end else begin
               cmd.apply = APPLY_LEFT;
               state_in  = ST_RESULT;
            end
         end
         ST_APPLY_RELOAD: begin
            cmd.apply = APPLY_RELOAD;
            state_in  = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |=> rsp_valid);
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_ready);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

[rtl/ddpu_datapath.sv]
// ----------------------------------------------------------------------------
// ddpu_datapath
// Wheel state, step-per-cycle CORDIC, offset multiply and result register.
// ----------------------------------------------------------------------------
module ddpu_datapath
   import ddpu_pkg::*;
#(
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT,
   parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic signed [15:0] left_speed,
   input  logic signed [15:0] right_speed,
   input  logic               reload,
   input  logic [9:0]         half_base,
   input  logic [31:0]        start_x,
   input  logic [31:0]        start_y,
   input  logic [15:0]        start_heading,
   output logic signed [31:0] center_x,
   output logic signed [31:0] center_y,
   output logic [15:0]        heading,
   output logic signed [31:0] left_wheel_x_out,
   output logic signed [31:0] right_wheel_x_out
);

   localparam int PW = POSITION_WIDTH;
   localparam int AW = ANGLE_WIDTH;
   localparam int AS = TURN_BITS - AW;
   localparam int PRODW = PW + TRIG_WIDTH + 1;

   logic signed [PW-1:0] lx_ff, ly_ff, rx_ff, ry_ff;
   logic [AW-1:0]        head_ff;
   logic signed [15:0]   ls_ff, rs_ff;
   logic                 rel_ff;
   logic signed [31:0]   cx_ff, cy_ff, cos_ff, sin_ff;
   logic signed [28:0]   z_ff;
   logic [1:0]           q_ff;
   logic [STEP_BITS-1:0] i_ff;

   function automatic logic [AW-1:0] turn_step(input logic signed [15:0] s);
      logic signed [33:0] p;
      p = 34'(s) * $signed({1'b0, STEP_GAIN}) + 34'(64'sd1 <<< (31 - AW));
      return p[32-AW +: AW];
   endfunction

   logic [AW-1:0] ang_right, ang_left, ang_start, ang_sel;
   assign ang_right = head_ff + turn_step(rs_ff);
   assign ang_left  = head_ff - turn_step(ls_ff);
   assign ang_start = AW'(({12'd0, start_heading} << 12) >> AS);

   always_comb begin
      ang_sel = head_ff;
      if (cmd.start_right) ang_sel = ang_right;
      if (cmd.start_left)  ang_sel = ang_left;
      if (cmd.start_reload) ang_sel = ang_start;
   end

   logic [27:0] zfull;
   assign zfull = 28'({ang_sel, {AS{1'b0}}});

   logic signed [31:0] xs, ys;
   assign xs = cos_ff >>> i_ff;
   assign ys = sin_ff >>> i_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else if (cmd.start_right || cmd.start_left || cmd.start_reload) begin
         head_ff <= ang_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ls_ff  <= left_speed;
         rs_ff  <= right_speed;
         rel_ff <= reload;
      end
      if (cmd.start_right || cmd.start_left || cmd.start_reload) begin
         q_ff    <= zfull[27:26];
         z_ff    <= $signed({3'd0, zfull[25:0]});
         cos_ff  <= $signed(CORDIC_X0);
         sin_ff  <= '0;
         i_ff    <= '0;
      end else if (cmd.cordic_step) begin
         if (!z_ff[28]) begin
            cos_ff <= cos_ff - ys;
            sin_ff <= sin_ff + xs;
            z_ff   <= z_ff - $signed({1'b0, atan_unit(i_ff)});
         end else begin
            cos_ff <= cos_ff + ys;
            sin_ff <= sin_ff - xs;
            z_ff   <= z_ff + $signed({1'b0, atan_unit(i_ff)});
         end
         i_ff <= i_ff + 1'b1;
      end
   end

   assign status.reload      = rel_ff;
   assign status.right_moves = (rs_ff != 16'sd0);
   assign status.left_moves  = (ls_ff != 16'sd0);
   assign status.cordic_last = (i_ff == STEP_BITS'(CORDIC_STEPS - 1));

   logic signed [31:0] c_q, s_q;
   always_comb begin
      case (q_ff)
         2'd0: begin c_q = cos_ff;  s_q = sin_ff;  end
         2'd1: begin c_q = -sin_ff; s_q = cos_ff;  end
         2'd2: begin c_q = -cos_ff; s_q = -sin_ff; end
         default: begin c_q = sin_ff; s_q = -cos_ff; end
      endcase
   end

   logic signed [23:0] len;
   assign len = (cmd.apply == APPLY_RELOAD) ? $signed({2'b0, half_base, 12'd0})
                                            : $signed({1'b0, half_base, 13'd0});
   logic signed [PRODW-1:0] pc, ps;
   logic signed [PW-1:0]    oc, os;
   assign pc = PRODW'(len) * PRODW'(c_q) + PRODW'(64'sd1 <<< 29);
   assign ps = PRODW'(len) * PRODW'(s_q) + PRODW'(64'sd1 <<< 29);
   assign oc = PW'(pc >>> 30);
   assign os = PW'(ps >>> 30);

   logic signed [PW-1:0] sx, sy;
   assign sx = PW'($signed(start_x));
   assign sy = PW'($signed(start_y));

   always_ff @(posedge clock) begin
      if (reset) begin
         lx_ff   <= -(PW'(20) <<< FRAC_BITS);
         ly_ff   <= '0;
         rx_ff   <= PW'(20) <<< FRAC_BITS;
         ry_ff   <= '0;
      end else begin
         unique case (cmd.apply)
            APPLY_RIGHT: begin
               rx_ff <= lx_ff + oc;
               ry_ff <= ly_ff - os;
            end
            APPLY_LEFT: begin
               lx_ff <= rx_ff - oc;
               ly_ff <= ry_ff + os;
            end
            APPLY_RELOAD: begin
               lx_ff <= sx - oc;
               ly_ff <= sy + os;
               rx_ff <= sx + oc;
               ry_ff <= sy - os;
            end
            default: ;
         endcase
      end
   end

   logic signed [PW:0] sumx, sumy;
   assign sumx = (PW+1)'(lx_ff) + (PW+1)'(rx_ff);
   assign sumy = (PW+1)'(ly_ff) + (PW+1)'(ry_ff);

   logic [27:0] hturn;
   assign hturn = 28'({head_ff, {AS{1'b0}}});

   logic [15:0] hd_ff;
   logic signed [31:0] lo_ff, ro_ff;
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         cx_ff <= 32'(PW'(sumx >>> 1));
         cy_ff <= 32'(PW'(sumy >>> 1));
         hd_ff <= hturn[27:12];
         lo_ff <= 32'(lx_ff);
         ro_ff <= 32'(rx_ff);
      end
   end

   assign center_x          = cx_ff;
   assign center_y          = cy_ff;
   assign heading           = hd_ff;
   assign left_wheel_x_out  = lo_ff;
   assign right_wheel_x_out = ro_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.cordic_step |-> cmd.apply == APPLY_NONE);
   assert property (@(posedge clock) disable iff (reset)
      cmd.start_left |-> !rel_ff);
   assert property (@(posedge clock) disable iff (reset)
      cmd.start_right |-> !rel_ff);

endmodule

[rtl/differential_drive_pose_update.sv]
// ----------------------------------------------------------------------------
// differential_drive_pose_update
// Two-wheel odometry with fixed-point CORDIC trigonometry.
// ----------------------------------------------------------------------------
// One item at a time. A tick with both wheels moving runs, from the accepting
// edge to the edge that loads the result, a set-up state, one 16-step CORDIC
// pass per moving wheel at one step per cycle, one apply state per swing and
// the result state. A tick with one wheel moving runs one pass, as does a
// reload; a standstill tick has only the set-up and result states. A single
// shared CORDIC unit does every pass. The result register holds while rsp_ready
// is low; a new transaction is accepted from the cycle after the result load.
module differential_drive_pose_update
   import ddpu_pkg::*;
#(
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT,
   parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   ddpu_req_if.sink                  req,
   ddpu_rsp_if.source                rsp,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   logic [9:0]  half_base_ff;
   logic [31:0] start_x_ff, start_y_ff;
   logic [15:0] start_heading_ff;
   logic        wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_base_ff     <= 10'd20;
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         start_heading_ff <= '0;
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         unique case (csr_paddr[3:2])
            REG_HALF_BASE:     half_base_ff     <= csr_pwdata[9:0];
            REG_START_X:       start_x_ff       <= csr_pwdata;
            REG_START_Y:       start_y_ff       <= csr_pwdata;
            REG_START_HEADING: start_heading_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_HALF_BASE:     csr_prdata = {22'd0, half_base_ff};
         REG_START_X:       csr_prdata = start_x_ff;
         REG_START_Y:       csr_prdata = start_y_ff;
         REG_START_HEADING: csr_prdata = {16'd0, start_heading_ff};
         default:           csr_prdata = '0;
      endcase
   end

   cmd_type    cmd;
   status_type status;

   ddpu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ddpu_datapath #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .ANGLE_WIDTH    (ANGLE_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .left_speed        (req.left_speed),
      .right_speed       (req.right_speed),
      .reload            (req.reload),
      .half_base         (half_base_ff),
      .start_x           (start_x_ff),
      .start_y           (start_y_ff),
      .start_heading     (start_heading_ff),
      .center_x          (rsp.center_x),
      .center_y          (rsp.center_y),
      .heading           (rsp.heading),
      .left_wheel_x_out  (rsp.left_wheel_x_out),
      .right_wheel_x_out (rsp.right_wheel_x_out)
   );

endmodule
